// ===== sv/delimiter_message_deframer_assert.svh =====
// assertion macros for the delimiter message deframer
`ifndef DELIMITER_MESSAGE_DEFRAMER_ASSERT_SVH
`define DELIMITER_MESSAGE_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, checked out of reset
`define DMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== sv/dmd_pkg.sv =====
// shared constants, types and helpers of the delimiter message deframer
package dmd_pkg;

    localparam int MAX_DELIM = 8;
    localparam int LEN_BITS  = 16;
    localparam int CNT_W     = $clog2(MAX_DELIM + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 2'd1;

    localparam logic [3:0]  DELIM_LEN_RST   = 4'd1;
    localparam logic [63:0] DELIM_BYTES_RST = 64'd10;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic take_new;
        logic shift;
    } cell_ctl_t;

    // delimiter byte at a position, zero from position eight on
    function automatic logic [7:0] delim_byte_at(input logic [63:0] bytes, input int idx);
        if (idx >= 8)
        begin
            return 8'h00;
        end
        return bytes[8*idx +: 8];
    endfunction

endpackage

// ===== sv/dmd_cell.sv =====
// one window cell: holds a byte, compares it with its delimiter byte
module dmd_cell (
    input  logic              clk,
    input  dmd_pkg::cell_ctl_t ctl,
    input  logic [7:0]        new_byte,
    input  logic [7:0]        right_byte,
    input  logic [7:0]        delim_byte,
    output logic [7:0]        held_byte,
    output logic              eq
);
    import dmd_pkg::*;

    logic [7:0] held_reg;
    logic [7:0] held_next;

    always_comb
    begin
        held_next = held_reg;
        if (ctl.take_new)
        begin
            held_next = new_byte;
        end
        else if (ctl.shift)
        begin
            held_next = right_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    assign held_byte = held_reg;
    assign eq        = (held_reg == delim_byte);

endmodule

// ===== sv/delimiter_message_deframer.sv =====
// delimiter message deframer top level: window cell chain, framing control, output register
// a result appears in the output register in the cycle after its byte is taken
// throughput: one byte per cycle unless the receiver stalls; all cells compare at once
// a byte that is held back or filling the window gives no result
// reset: delimiter length 1, delimiter line feed, window empty, length count zero
// reset is asynchronous; the output register comes out of reset empty
`include "delimiter_message_deframer_assert.svh"

module delimiter_message_deframer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [7:0]                       payload_byte,
    output logic [15:0]                      message_length,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                      cfg_data
);
    import dmd_pkg::*;

    logic [3:0]          delim_len_reg;
    logic [3:0]          delim_len_next;
    logic [63:0]         delim_bytes_reg;
    logic [63:0]         delim_bytes_next;
    logic [CNT_W-1:0]    held_cnt_reg;
    logic [CNT_W-1:0]    held_cnt_next;
    logic [LEN_BITS-1:0] len_cnt_reg;
    logic [LEN_BITS-1:0] len_cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                kind_reg;
    logic                kind_next;
    logic [7:0]          payload_reg;
    logic [7:0]          payload_next;
    logic [15:0]         msg_len_reg;
    logic [15:0]         msg_len_next;

    logic [CNT_W-1:0]    eff_len;
    logic [CNT_W-1:0]    hold;
    logic                in_fire;
    logic                cfg_fire;
    logic                framing;
    logic                filling;
    logic                is_match;
    logic                produce;
    logic [7:0]          oldest;
    logic [MAX_DELIM-1:0] cell_eq;
    logic [MAX_DELIM-1:0] in_window;
    logic [7:0]          cell_byte [MAX_DELIM];
    cell_ctl_t           cell_ctl  [MAX_DELIM];

    assign in_fire  = in_valid && in_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (32'(delim_len_reg) > MAX_DELIM)
        begin
            eff_len = CNT_W'(MAX_DELIM);
        end
        else
        begin
            eff_len = CNT_W'(delim_len_reg);
        end
    end

    assign framing  = (eff_len != '0);
    assign hold     = framing ? (eff_len - CNT_W'(1)) : '0;
    assign filling  = framing && (held_cnt_reg < hold);
    assign is_match = framing && !filling
                      && (data_byte == delim_byte_at(delim_bytes_reg, int'(hold)))
                      && (&(cell_eq | ~in_window));
    assign oldest   = (hold == '0) ? data_byte : cell_byte[0];
    assign produce  = in_fire && !filling;

    genvar k;
    generate
        for (k = 0; k < MAX_DELIM; k++)
        begin : g_cell
            logic [7:0] right_byte;

            if (k == MAX_DELIM - 1)
            begin : g_last
                assign right_byte = 8'h00;
            end
            else
            begin : g_inner
                assign right_byte = cell_byte[k+1];
            end

            assign in_window[k] = (CNT_W'(k) < hold);
            assign cell_ctl[k].take_new = in_fire && framing
                && ((filling && (held_cnt_reg == CNT_W'(k)))
                    || (!filling && !is_match && (hold == CNT_W'(k + 1))));
            assign cell_ctl[k].shift = in_fire && framing && !filling && !is_match;

            dmd_cell u_cell (
                .clk        (clk),
                .ctl        (cell_ctl[k]),
                .new_byte   (data_byte),
                .right_byte (right_byte),
                .delim_byte (delim_byte_at(delim_bytes_reg, k)),
                .held_byte  (cell_byte[k]),
                .eq         (cell_eq[k])
            );
        end
    endgenerate

    always_comb
    begin
        delim_len_next   = delim_len_reg;
        delim_bytes_next = delim_bytes_reg;
        held_cnt_next    = held_cnt_reg;
        len_cnt_next     = len_cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        kind_next        = kind_reg;
        payload_next     = payload_reg;
        msg_len_next     = msg_len_reg;

        if (in_fire)
        begin
            if (filling)
            begin
                held_cnt_next = held_cnt_reg + CNT_W'(1);
            end
            else if (is_match)
            begin
                held_cnt_next = '0;
                len_cnt_next  = '0;
            end
            else if (len_cnt_reg != '1)
            begin
                len_cnt_next = len_cnt_reg + LEN_BITS'(1);
            end
        end

        if (produce)
        begin
            out_valid_next = 1'b1;
            if (is_match)
            begin
                kind_next    = KIND_END;
                payload_next = 8'h00;
                msg_len_next = 16'(len_cnt_reg);
            end
            else
            begin
                kind_next    = KIND_PAYLOAD;
                payload_next = framing ? oldest : data_byte;
                msg_len_next = 16'h0000;
            end
        end

        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_DELIM_LEN:
                begin
                    delim_len_next = cfg_data[3:0];
                    held_cnt_next  = '0;
                    len_cnt_next   = '0;
                end
                REG_DELIM_BYTES:
                begin
                    delim_bytes_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_len_reg   <= DELIM_LEN_RST;
            delim_bytes_reg <= DELIM_BYTES_RST;
            held_cnt_reg    <= '0;
            len_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            delim_len_reg   <= delim_len_next;
            delim_bytes_reg <= delim_bytes_next;
            held_cnt_reg    <= held_cnt_next;
            len_cnt_reg     <= len_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        payload_reg <= payload_next;
        msg_len_reg <= msg_len_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = payload_reg;
    assign message_length = msg_len_reg;

    // window never holds more than the effective delimiter length (capped at eight) minus one
    `DMD_ASSERT_NOW(a_held_bound, 1'b1, held_cnt_reg <= hold)
    // an end mark restarts framing
    `DMD_ASSERT_NEXT(a_match_clears, in_fire && is_match && !cfg_fire, (held_cnt_reg == '0) && (len_cnt_reg == '0))
    // a waiting result is not dropped
    `DMD_ASSERT_NEXT(a_out_keeps, out_valid_reg && !out_ready, out_valid_reg)
    // pass-through gives a payload byte for every transfer
    `DMD_ASSERT_NEXT(a_pass_through, in_fire && !framing, out_valid_reg && (kind_reg == KIND_PAYLOAD))

endmodule

// ===== test/deframe_checker.sv =====
// scoreboard for the delimiter message deframer: predicts and checks each result
`timescale 1ns / 100ps

module deframe_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          kind,
    input  logic [7:0]                    payload_byte,
    input  logic [15:0]                   message_length,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [dmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output int                            pending,
    output int                            fail_count
);
    import dmd_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload;
        logic [15:0] msg_len;
    } frame_t;

    logic [3:0]          len_reg;
    logic [63:0]         delim_reg;
    logic [7:0]          held_win [MAX_DELIM];
    int unsigned         held_n;
    logic [LEN_BITS-1:0] run_len;
    frame_t              due_q [$];

    // one byte through the framer; returns 1 when it yields a result
    function automatic bit deframe_byte(input logic [7:0] b, output frame_t res);
        int unsigned eff;
        int unsigned hold;
        int unsigned k;
        bit          hit;
        res = '0;
        res.kind = KIND_PAYLOAD;
        eff = (len_reg > MAX_DELIM) ? MAX_DELIM : len_reg;
        hold = (eff == 0) ? 0 : eff - 1;
        if (eff == 0)
        begin
            res.payload = b;
        end
        else if (held_n < hold)
        begin
            held_win[held_n] = b;
            held_n++;
            return 1'b0;
        end
        else
        begin
            hit = (b == delim_reg[8*hold +: 8]);
            for (k = 0; k < hold; k++)
            begin
                if (held_win[k] != delim_reg[8*k +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                res.kind = KIND_END;
                res.msg_len = run_len[15:0];
                held_n = 0;
                run_len = '0;
                return 1'b1;
            end
            if (hold == 0)
            begin
                res.payload = b;
            end
            else
            begin
                res.payload = held_win[0];
                for (k = 0; k + 1 < hold; k++)
                begin
                    held_win[k] = held_win[k + 1];
                end
                held_win[hold - 1] = b;
            end
        end
        // count saturates at all ones
        if (run_len != '1)
        begin
            run_len++;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            len_reg = DELIM_LEN_RST;
            delim_reg = DELIM_BYTES_RST;
            foreach (held_win[i])
            begin
                held_win[i] = '0;
            end
            held_n = 0;
            run_len = '0;
            due_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DELIM_LEN)
                begin
                    // new length restarts framing
                    len_reg = cfg_data[3:0];
                    foreach (held_win[i])
                    begin
                        held_win[i] = '0;
                    end
                    held_n = 0;
                    run_len = '0;
                end
                else if (cfg_index == REG_DELIM_BYTES)
                begin
                    delim_reg = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                if (deframe_byte(data_byte, want))
                begin
                    due_q.insert(due_q.size(), want);
                end
            end
            if (out_valid && out_ready)
            begin
                if (due_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d payload_byte %0h message_length %0d",
                           kind, payload_byte, message_length);
                    fail_count++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        fail_count++;
                    end
                    if (payload_byte !== want.payload)
                    begin
                        $error("payload_byte: expected %0h, got %0h", want.payload, payload_byte);
                        fail_count++;
                    end
                    if (message_length !== want.msg_len)
                    begin
                        $error("message_length: expected %0d, got %0d",
                               want.msg_len, message_length);
                        fail_count++;
                    end
                end
            end
            pending = due_q.size();
        end
    end

endmodule

// ===== test/tb_delimiter_message_deframer.sv =====
// testbench top for the delimiter message deframer: stimulus, configuration phases and verdict
`timescale 1ns / 100ps

module tb_delimiter_message_deframer;
    import dmd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_RUN     = 40;
    localparam int SEG_ITEMS    = 56;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind;
    logic [7:0]           payload_byte;
    logic [15:0]          message_length;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    int                   pending;
    int                   fail_count;

    bit                   steady = 1'b0;
    int unsigned          bytes_sent = 0;
    int unsigned          cur_len = 1;
    logic [63:0]          cur_delim = DELIM_BYTES_RST;

    delimiter_message_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .message_length (message_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    deframe_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .message_length (message_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending        (pending),
        .fail_count     (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_delimiter_message_deframer: done, errors");
        $finish;
    end

    // receiver backpressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= steady || ($urandom_range(99) >= 7);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // hold off input until every expected result is out, then let held work settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_len(input logic [63:0] val);
        write_reg(REG_DELIM_LEN, val);
        cur_len = (val[3:0] > MAX_DELIM) ? MAX_DELIM : val[3:0];
    endtask

    task automatic set_delim(input logic [63:0] val);
        write_reg(REG_DELIM_BYTES, val);
        cur_delim = val;
    endtask

    task automatic send_delim();
        for (int k = 0; k < cur_len; k++)
        begin
            send_byte(cur_delim[8*k +: 8]);
        end
    endtask

    initial
    begin
        int          lens [6];
        int unsigned seg_len;
        int unsigned base;
        int unsigned pick;
        int unsigned n;
        logic [63:0] dval;
        bit          paused;

        lens = '{1, 8, 3, 15, 0, 2};
        paused = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: line feed, one byte; spare indexes must not disturb it
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, {$urandom, $urandom});
        send_byte(8'h0A);
        send_byte(8'h0A);

        // two byte delimiter with a repeated first byte
        set_len(64'd2);
        set_delim(64'h0A0D);
        send_byte(8'h78);
        send_byte(8'h0D);
        send_byte(8'h0D);
        send_byte(8'h0A);

        // length field of 15 acts as the widest delimiter
        set_len('1);
        set_delim({$urandom, $urandom});
        send_delim();

        // pass-through
        set_len(64'd0);
        send_byte(8'h0A);
        send_byte(8'h55);

        // delimiter change keeps the held bytes
        set_len(64'd3);
        set_delim(64'd0);
        send_byte(8'h11);
        send_byte(8'h22);
        set_delim(64'h332211);
        send_byte(8'h33);

        // longer message, then an empty one
        set_len(64'd1);
        set_delim(64'd0);
        repeat (LONG_RUN) send_byte(8'($urandom_range(1, 255)));
        send_byte(8'h00);
        send_byte(8'h00);

        for (int seg = 0; seg < 7; seg++)
        begin
            seg_len = (seg < 6) ? lens[seg] : $urandom_range(15);
            dval = ($urandom_range(3) == 0) ? {8{8'($urandom)}} : {$urandom, $urandom};
            if (seg % 2 == 1)
            begin
                set_delim(dval);
                set_len(({$urandom, $urandom} & ~64'hF) | 64'(seg_len));
            end
            else
            begin
                set_len(({$urandom, $urandom} & ~64'hF) | 64'(seg_len));
                set_delim(dval);
            end
            steady = (seg == 3);
            base = bytes_sent;
            while (bytes_sent - base < SEG_ITEMS)
            begin
                if (seg == 1 && !paused && bytes_sent - base > SEG_ITEMS / 2)
                begin
                    paused = 1'b1;
                    wait_idle();
                end
                pick = $urandom_range(9);
                if (cur_len == 0 || pick == 9)
                begin
                    repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
                end
                else if (pick >= 7)
                begin
                    // broken delimiter: a prefix and then a random byte
                    n = $urandom_range(cur_len - 1);
                    for (int k = 0; k < n; k++)
                    begin
                        send_byte(cur_delim[8*k +: 8]);
                    end
                    send_byte(8'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(10)) send_byte(8'($urandom));
                    send_delim();
                end
            end
        end
        steady = 1'b0;

        wait_idle();
        if (fail_count == 0)
        begin
            $display("tb_delimiter_message_deframer: done, clean");
        end
        else
        begin
            $display("tb_delimiter_message_deframer: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dmd_pkg.sv
sv/dmd_cell.sv
sv/delimiter_message_deframer.sv
test/deframe_checker.sv
test/tb_delimiter_message_deframer.sv
